/* hdl/scpc_pkg.sv */
// Shared types and constants for the sheet counter period classifier.
package scpc_pkg;

	// Request kinds carried in the slave-side tuser.
	localparam logic [2:0] REQ_PULSE = 3'd0;
	localparam logic [2:0] REQ_EDGE  = 3'd1;
	localparam logic [2:0] REQ_TICK  = 3'd2;
	localparam logic [2:0] REQ_EVAL  = 3'd3;
	localparam logic [2:0] REQ_CLEAR = 3'd4;

	// Machine mode codes as reported on the result.
	localparam logic [1:0] MODE_RUN   = 2'd0;
	localparam logic [1:0] MODE_EMPTY = 2'd1;
	localparam logic [1:0] MODE_STOP  = 2'd2;

	// Configuration register indexes.
	localparam logic [7:0] CFG_IDLE_EDGES = 8'd0;
	localparam logic [7:0] CFG_TIMEOUT    = 8'd1;

	// Edge count of a sheet split in two while running empty.
	localparam int SPLIT_EDGES = 3;

	// Reset values of the configuration registers.
	localparam logic [7:0]  IDLE_EDGES_RST = 8'd2;
	localparam logic [31:0] TIMEOUT_RST    = 32'd1000000;

	// Outcome of classifying one closed period.
	typedef struct packed {
		logic       counted;  // sheet count increments
		logic       hit;      // mode changes and closed period clears
		logic [1:0] mode;     // new mode when hit
	} cls_t;

endpackage

/* hdl/scpc_classify.sv */
// Classification of a closed period from its edge count and edge order.
module scpc_classify import scpc_pkg::*; #(
	parameter int EDGE_COUNT_BITS = 8
) (
	input  logic [EDGE_COUNT_BITS-1:0] edge_count,
	input  logic [1:0]                 levels,
	input  logic [7:0]                 idle_edges,
	input  logic [1:0]                 start_mode,
	output cls_t                       result
);

	localparam int CMP_W = (EDGE_COUNT_BITS > 8) ? EDGE_COUNT_BITS : 8;

	logic [CMP_W-1:0] cnt_ext;
	logic [CMP_W-1:0] idle_ext;
	logic             split_sheet;

	assign cnt_ext     = CMP_W'(edge_count);
	assign idle_ext    = CMP_W'(idle_edges);
	assign split_sheet = (start_mode == MODE_EMPTY) &&
	                     (edge_count == EDGE_COUNT_BITS'(SPLIT_EDGES));

	// Over idle edges is a sheet unless split when empty; equal needs rising then falling.
	always_comb begin
		result = '{counted: 1'b0, hit: 1'b0, mode: MODE_RUN};
		if (cnt_ext > idle_ext) begin
			result.hit     = 1'b1;
			result.counted = !split_sheet;
			result.mode    = MODE_RUN;
		end else if (cnt_ext == idle_ext) begin
			result.hit = 1'b1;
			if (levels[0] && !levels[1]) begin
				result.counted = 1'b1;
				result.mode    = MODE_RUN;
			end else begin
				result.mode = MODE_EMPTY;
			end
		end
	end

endmodule

/* hdl/sheet_counter_period_classifier_unit.sv */
// Top level of the sheet counter with period classifier.
//
// Items enter on the slave-side stream: tuser holds the request kind (period
// pulse, sensor edge, tick, evaluate, clear count) and tdata bit 0 the sensor
// level of an edge. Each accepted item yields exactly one result on the
// master-side stream: the sheet count, the machine mode and a flag that says
// whether this item counted a sheet.
// Configuration is written through the cfg channel, index 0 for the idle edge
// count and index 1 for the timeout in ticks; it is always ready and should
// only be written while no result is outstanding.
// The state update and the result are computed in the cycle of acceptance and the
// result register presents them on the next edge.
// Throughput is one item per cycle while the receiver keeps up, set by the single
// result register: a new item is taken whenever that register is empty or is
// emptied in the same cycle. When the receiver stalls, the result is held and
// s_axis_tready falls until it is taken.
// Reset clears the counts and periods, sets the mode to stopped and loads the
// default configuration; no result is pending afterwards.
module sheet_counter_period_classifier_unit import scpc_pkg::*; #(
	parameter int SHEET_BITS      = 32,
	parameter int EDGE_COUNT_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] edge_level, [7:1] zero
	input  logic [2:0]  s_axis_tuser,   // [2:0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [31:0] sheet_total, [33:32] machine_mode,
	                                    // [34] sheet_counted, [39:35] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [7:0]  idle_edges_q;
	logic [31:0] timeout_q;

	logic [1:0]                 mode_q, mode_d;
	logic                       pending_q, pending_d;
	logic [EDGE_COUNT_BITS-1:0] open_cnt_q, open_cnt_d;
	logic [1:0]                 open_lvl_q, open_lvl_d;
	logic [EDGE_COUNT_BITS-1:0] closed_cnt_q, closed_cnt_d;
	logic [1:0]                 closed_lvl_q, closed_lvl_d;
	logic [SHEET_BITS-1:0]      sheet_q, sheet_d;
	logic [31:0]                ticks_q, ticks_d;
	logic                       counted_d;

	logic        in_accept;
	logic [2:0]  req;
	logic        level;
	cls_t        cls;
	logic [63:0] sheet_ext;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign req           = s_axis_tuser;
	assign level         = s_axis_tdata[0];

	scpc_classify #(
		.EDGE_COUNT_BITS(EDGE_COUNT_BITS)
	) u_classify (
		.edge_count(closed_cnt_q),
		.levels    (closed_lvl_q),
		.idle_edges(idle_edges_q),
		.start_mode(mode_q),
		.result    (cls)
	);

	// Next state for the item on the input.
	always_comb begin
		mode_d       = mode_q;
		pending_d    = pending_q;
		open_cnt_d   = open_cnt_q;
		open_lvl_d   = open_lvl_q;
		closed_cnt_d = closed_cnt_q;
		closed_lvl_d = closed_lvl_q;
		sheet_d      = sheet_q;
		ticks_d      = ticks_q;
		counted_d    = 1'b0;
		case (req)
			REQ_PULSE: begin
				closed_cnt_d = open_cnt_q;
				closed_lvl_d = open_lvl_q;
				open_cnt_d   = '0;
				open_lvl_d   = '0;
				pending_d    = 1'b1;
				ticks_d      = '0;
			end
			REQ_EDGE: begin
				if (open_cnt_q < EDGE_COUNT_BITS'(2)) begin
					open_lvl_d[open_cnt_q[0]] = level;
				end
				if (open_cnt_q != '1) begin
					open_cnt_d = open_cnt_q + 1'b1;
				end
			end
			REQ_TICK: begin
				if (ticks_q != '1) begin
					ticks_d = ticks_q + 1'b1;
				end
			end
			REQ_EVAL: begin
				if (pending_q) begin
					pending_d = 1'b0;
					if (cls.hit) begin
						mode_d       = cls.mode;
						closed_cnt_d = '0;
						closed_lvl_d = '0;
					end
					if (cls.counted) begin
						counted_d = 1'b1;
						sheet_d   = sheet_q + 1'b1;
					end
				end
				if ((mode_q == MODE_RUN || mode_q == MODE_EMPTY) && ticks_q > timeout_q) begin
					mode_d = MODE_STOP;
				end
			end
			REQ_CLEAR: begin
				sheet_d = '0;
			end
			default: begin
			end
		endcase
	end

	assign sheet_ext = 64'(sheet_d);

	// Block state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_edges_q <= IDLE_EDGES_RST;
			timeout_q    <= TIMEOUT_RST;
			mode_q       <= MODE_STOP;
			pending_q    <= 1'b0;
			open_cnt_q   <= '0;
			open_lvl_q   <= '0;
			closed_cnt_q <= '0;
			closed_lvl_q <= '0;
			sheet_q      <= '0;
			ticks_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_IDLE_EDGES: idle_edges_q <= cfg_data[7:0];
					CFG_TIMEOUT:    timeout_q    <= cfg_data;
					default: begin
					end
				endcase
			end
			if (in_accept) begin
				mode_q       <= mode_d;
				pending_q    <= pending_d;
				open_cnt_q   <= open_cnt_d;
				open_lvl_q   <= open_lvl_d;
				closed_cnt_q <= closed_cnt_d;
				closed_lvl_q <= closed_lvl_d;
				sheet_q      <= sheet_d;
				ticks_q      <= ticks_d;
			end
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (s_axis_tready) begin
			m_axis_tvalid <= s_axis_tvalid;
		end
	end

	// Result payload, loaded with each accepted item.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			m_axis_tdata <= {5'b0, counted_d, mode_d, sheet_ext[31:0]};
		end
	end

endmodule

/* hdl/scpc_check.sv */
// Port-level checks on the sheet counter period classifier, bound to its top level.
module scpc_check import scpc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);

	// An empty result register must always take an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with no result pending");

	// Every accepted item gives a result on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("accepted item produced no result");

	// A counted sheet never leaves the machine running empty; a timeout may still stop it.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[34] |-> m_axis_tdata[33:32] != MODE_EMPTY)
		else $error("sheet counted while left running empty");

	// A stalled result holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind sheet_counter_period_classifier_unit scpc_check u_scpc_check (.*);

/* verif/tb_top.sv */
// Self-checking testbench for the sheet counter with period classifier.
`timescale 1ns / 1ps

module tb_top import scpc_pkg::*;;

	// Request codes beyond the defined ones, which the block ignores.
	localparam logic [2:0] REQ_RESERVED_FIRST = 3'd5;
	// Register indexes that select no register.
	localparam logic [7:0] CFG_NO_REG_NEXT = 8'd2;
	localparam logic [7:0] CFG_NO_REG_TOP  = 8'hFF;
	localparam logic [7:0] EDGE_COUNT_TOP  = 8'hFF;
	localparam logic [31:0] TICK_COUNT_TOP = 32'hFFFF_FFFF;
	localparam int HOLD_CYCLES = 60;

	typedef struct {
		logic [2:0] req;
		logic       level;
	} sensor_item_t;

	typedef struct {
		logic [31:0] total;
		logic [1:0]  mode;
		logic        counted;
	} sheet_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;    // [0] edge_level, [7:1] zero
	logic [2:0]  s_axis_tuser = '0;    // [2:0] req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;         // [31:0] sheet_total, [33:32] machine_mode,
	                                   // [34] sheet_counted, [39:35] zero
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	sheet_counter_period_classifier_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Items waiting to be sent and counts expected back, in order.
	sensor_item_t  sensor_events[$];
	sheet_result_t pending_counts[$];

	int items_queued = 0;
	int items_accepted = 0;
	int results_seen = 0;
	int sheets_seen = 0;
	int stops_seen = 0;
	int fail_count = 0;
	bit quiet = 1'b0;
	int hold_request = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int src_gap = 0;
	int sink_stall = 0;

	// Own copy of the configuration and of the block state.
	logic [7:0]  idle_edges = IDLE_EDGES_RST;
	logic [31:0] timeout_ticks = TIMEOUT_RST;
	logic [1:0]  mode_now = MODE_STOP;
	logic        period_waiting = 1'b0;
	logic [7:0]  open_edges = '0;
	logic [1:0]  open_levels = '0;
	logic [7:0]  closed_edges = '0;
	logic [1:0]  closed_levels = '0;
	logic [31:0] sheet_count = '0;
	logic [31:0] ticks_since = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Work out the result of one item and advance the own copy of the state.
	function void predict_sheet_count(input logic [2:0] req, input logic level);
		logic [1:0] start_mode;
		logic       counted;
		sheet_result_t res;
		counted = 1'b0;
		case (req)
			REQ_PULSE: begin
				closed_edges = open_edges;
				closed_levels = open_levels;
				open_edges = '0;
				open_levels = '0;
				period_waiting = 1'b1;
				ticks_since = '0;
			end
			REQ_EDGE: begin
				if (open_edges < 8'd2)
					open_levels[open_edges[0]] = level;
				if (open_edges != EDGE_COUNT_TOP)
					open_edges = open_edges + 8'd1;
			end
			REQ_TICK: begin
				if (ticks_since != TICK_COUNT_TOP)
					ticks_since = ticks_since + 32'd1;
			end
			REQ_EVAL: begin
				start_mode = mode_now;
				if (period_waiting) begin
					period_waiting = 1'b0;
					if (closed_edges > idle_edges) begin
						// A sheet split in two while running empty is not counted.
						counted = !(start_mode == MODE_EMPTY && closed_edges == SPLIT_EDGES);
						mode_now = MODE_RUN;
						closed_edges = '0;
						closed_levels = '0;
					end else if (closed_edges == idle_edges) begin
						if (closed_levels == 2'b01) begin
							counted = 1'b1;
							mode_now = MODE_RUN;
						end else begin
							mode_now = MODE_EMPTY;
						end
						closed_edges = '0;
						closed_levels = '0;
					end
					if (counted)
						sheet_count = sheet_count + 32'd1;
				end
				// The timeout overrides whatever the classification chose.
				if ((start_mode == MODE_RUN || start_mode == MODE_EMPTY)
						&& ticks_since > timeout_ticks)
					mode_now = MODE_STOP;
			end
			REQ_CLEAR: sheet_count = '0;
			default: ;
		endcase
		res.total = sheet_count;
		res.mode = mode_now;
		res.counted = counted;
		pending_counts.push_back(res);
	endfunction

	function int idle_draw();
		return quiet ? 0 : int'($urandom_range(0, 7));
	endfunction

	// Source side: offers queued items, with a random gap between them.
	always @(posedge clk or negedge arst_n) begin : sensor_source
		sensor_item_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			src_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_sheet_count(s_axis_tuser, s_axis_tdata[0]);
				items_accepted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_gap != 0) begin
					src_gap <= src_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (sensor_events.size() != 0) begin
					nxt = sensor_events.pop_front();
					s_axis_tuser <= nxt.req;
					s_axis_tdata <= {7'd0, nxt.level};
					s_axis_tvalid <= 1'b1;
					src_gap <= idle_draw();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	function void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// Sink side: checks each result and stalls at random or on request.
	always @(posedge clk or negedge arst_n) begin : count_sink
		int wait_n;
		sheet_result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_stall <= 0;
			hold_left <= 0;
		end else begin
			wait_n = sink_stall;
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (pending_counts.size() == 0) begin
					$display("%0t: result with no item outstanding, actual %h",
						$time, m_axis_tdata);
					fail_count++;
				end else begin
					want = pending_counts.pop_front();
					check_field("sheet_total", want.total, m_axis_tdata[31:0]);
					check_field("machine_mode", want.mode, m_axis_tdata[33:32]);
					check_field("sheet_counted", want.counted, m_axis_tdata[34]);
					if (want.counted)
						sheets_seen++;
					if (want.mode == MODE_STOP)
						stops_seen++;
				end
				wait_n = idle_draw();
			end
			if (hold_seen != hold_request) begin
				hold_seen <= hold_request;
				hold_left <= HOLD_CYCLES;
				sink_stall <= wait_n;
				m_axis_tready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				sink_stall <= wait_n;
				m_axis_tready <= 1'b0;
			end else if (wait_n != 0) begin
				sink_stall <= wait_n - 1;
				m_axis_tready <= 1'b0;
			end else begin
				sink_stall <= 0;
				m_axis_tready <= 1'b1;
			end
		end
	end

	function void queue_item(input logic [2:0] req, input logic level);
		sensor_item_t it;
		it.req = req;
		it.level = level;
		sensor_events.push_back(it);
		items_queued++;
	endfunction

	// One machine cycle: edges, closing pulse, ticks, an evaluate and at times one more item.
	function void add_period(input int n_edges, input int n_ticks);
		bit ordered;
		int r;
		ordered = $urandom_range(0, 1);
		for (int i = 0; i < n_edges; i++) begin
			queue_item(REQ_EDGE, (ordered && i < 2) ? (i == 0) : 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 3) == 0)
				queue_item(REQ_TICK, 1'($urandom_range(0, 1)));
		end
		queue_item(REQ_PULSE, 1'($urandom_range(0, 1)));
		for (int i = 0; i < n_ticks; i++)
			queue_item(REQ_TICK, 1'($urandom_range(0, 1)));
		queue_item(REQ_EVAL, 1'($urandom_range(0, 1)));
		r = $urandom_range(0, 9);
		if (r == 0)
			queue_item(REQ_EVAL, 1'($urandom_range(0, 1)));
		else if (r == 1)
			queue_item(REQ_CLEAR, 1'($urandom_range(0, 1)));
		else if (r == 2)
			queue_item(REQ_RESERVED_FIRST + 3'($urandom_range(0, 2)), 1'($urandom_range(0, 1)));
	endfunction

	// Edge counts around the idle count, plus the split-sheet count and a random count up to six.
	function int pick_edges(input int idle);
		int r;
		int n;
		r = $urandom_range(0, 9);
		if (r < 5) begin
			n = idle + int'($urandom_range(0, 2)) - 1;
			return (n < 0) ? 0 : n;
		end else if (r < 8) begin
			return SPLIT_EDGES;
		end
		return $urandom_range(0, 6);
	endfunction

	function void add_random_periods(input int idle, input int tick_span, input int n_items);
		int stop_at;
		stop_at = items_queued + n_items;
		while (items_queued < stop_at) begin
			if ($urandom_range(0, 7) == 0)
				queue_item(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
			else
				add_period(pick_edges(idle), $urandom_range(0, tick_span));
		end
	endfunction

	task automatic write_setting(input logic [7:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_IDLE_EDGES: idle_edges = val[7:0];
			CFG_TIMEOUT: timeout_ticks = val;
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (items_accepted != items_queued || results_seen != items_queued);
	endtask

	initial begin
		wait (arst_n === 1'b1);

		// Directed: ignored codes, evaluate without a period, each classification.
		queue_item(REQ_RESERVED_FIRST, 1'b1);
		queue_item(REQ_RESERVED_FIRST + 3'd1, 1'b0);
		queue_item(REQ_RESERVED_FIRST + 3'd2, 1'b1);
		queue_item(REQ_EVAL, 1'b1);
		// Idle count of edges in the sheet order, then in the wrong order.
		queue_item(REQ_EDGE, 1'b1);
		queue_item(REQ_EDGE, 1'b0);
		queue_item(REQ_PULSE, 1'b0);
		queue_item(REQ_EVAL, 1'b0);
		queue_item(REQ_EDGE, 1'b0);
		queue_item(REQ_EDGE, 1'b1);
		queue_item(REQ_PULSE, 1'b1);
		queue_item(REQ_EVAL, 1'b0);
		// Split sheet while running empty, then a normal sheet.
		for (int k = 0; k < 2; k++) begin
			repeat (3) queue_item(REQ_EDGE, 1'b1);
			queue_item(REQ_PULSE, 1'b0);
			queue_item(REQ_EVAL, 1'b1);
		end
		// Too few edges leaves everything as it was; then the count is cleared.
		queue_item(REQ_PULSE, 1'b0);
		queue_item(REQ_TICK, 1'b1);
		queue_item(REQ_EVAL, 1'b0);
		queue_item(REQ_CLEAR, 1'b1);
		wait_drained();

		// Short timeout; the sink holds off for a while as the source keeps offering.
		write_setting(CFG_IDLE_EDGES, 32'd2);
		write_setting(CFG_TIMEOUT, 32'd3);
		add_random_periods(2, 6, 200);
		hold_request++;
		wait_drained();

		// Lowest idle count and a short timeout.
		write_setting(CFG_IDLE_EDGES, 32'd0);
		write_setting(CFG_TIMEOUT, 32'd1);
		add_random_periods(0, 3, 150);
		wait_drained();

		// Highest settings: a long period saturates the edge count.
		write_setting(CFG_IDLE_EDGES, 32'd255);
		write_setting(CFG_TIMEOUT, 32'hFFFF_FFFF);
		add_period(300, 2);
		add_period(5, 1);
		for (int k = 0; k < 20; k++)
			queue_item(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
		wait_drained();

		// Back-to-back stretch with no idling on either side.
		quiet = 1'b1;
		write_setting(CFG_IDLE_EDGES, 32'd1);
		write_setting(CFG_TIMEOUT, 32'd2);
		add_random_periods(1, 4, 150);
		wait_drained();
		quiet = 1'b0;

		// Writes to no register change nothing; then noise and defaults.
		write_setting(CFG_NO_REG_TOP, 32'hFFFF_FFFF);
		write_setting(CFG_NO_REG_NEXT, 32'd0);
		write_setting(CFG_TIMEOUT, TIMEOUT_RST);
		write_setting(CFG_IDLE_EDGES, 32'(IDLE_EDGES_RST));
		for (int k = 0; k < 100; k++)
			queue_item(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
		add_random_periods(2, 3, 100);
		wait_drained();

		repeat (4) @(posedge clk);
		if (pending_counts.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_counts.size());
			fail_count++;
		end
		$display("Run covered %0d items over six settings, %0d sheets counted,", results_seen,
			sheets_seen);
		$display("%0d results in the stopped mode, %0d mismatches.", stops_seen, fail_count);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
